/* design/lcdtc_pkg.sv */
// Shared types and constants for the LCD timing controller.
// Holds the item and result payloads, opcodes, register offsets and reset values.
// No dependencies.
`default_nettype none

package lcdtc_pkg;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] byte_offset;
        logic [31:0] write_data;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        access_error;
        logic        hsync_pulse;
        logic        vsync_pulse;
        logic [31:0] line_number;
    } result_t;

    typedef struct packed {
        logic        enable;
        logic [31:0] period;
        logic [31:0] v_start;
        logic [31:0] v_end;
        logic [31:0] v_total;
    } timing_cfg_t;

    typedef struct packed {
        logic        hsync;
        logic        vsync;
        logic [31:0] line;
    } timing_status_t;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [11:0] OFS_CONTROL   = 12'h000;
    localparam logic [11:0] OFS_SYNC_DIFF = 12'h004;
    localparam logic [11:0] OFS_MODE      = 12'h008;
    localparam logic [11:0] OFS_HBP       = 12'h010;
    localparam logic [11:0] OFS_HSW       = 12'h014;
    localparam logic [11:0] OFS_HFP       = 12'h018;
    localparam logic [11:0] OFS_HRES      = 12'h01C;
    localparam logic [11:0] OFS_VBP       = 12'h020;
    localparam logic [11:0] OFS_VSW       = 12'h024;
    localparam logic [11:0] OFS_VFP       = 12'h028;
    localparam logic [11:0] OFS_VRES      = 12'h02C;
    localparam logic [11:0] OFS_SCALE0    = 12'h040;
    localparam logic [11:0] OFS_SCALE1    = 12'h044;
    localparam logic [11:0] OFS_SCALE2    = 12'h048;
    localparam logic [11:0] OFS_SCALE3    = 12'h04C;
    localparam logic [11:0] OFS_IGNORED   = 12'h070;

    localparam logic [31:0] RST_HBP  = 32'h0000_0029;
    localparam logic [31:0] RST_HSW  = 32'd2;
    localparam logic [31:0] RST_HFP  = 32'd2;
    localparam logic [31:0] RST_HRES = 32'h0000_01E0;
    localparam logic [31:0] RST_VBP  = 32'd2;
    localparam logic [31:0] RST_VSW  = 32'd2;
    localparam logic [31:0] RST_VFP  = 32'd10;
    localparam logic [31:0] RST_VRES = 32'h0000_0110;

    localparam logic [31:0] RST_PERIOD  = RST_HBP + RST_HSW + RST_HFP + RST_HRES;
    localparam logic [31:0] RST_VSTART  = RST_VSW + RST_VBP;
    localparam logic [31:0] RST_VEND    = RST_VSTART + RST_VRES;
    localparam logic [31:0] RST_VTOTAL  = RST_VEND + RST_VFP;

endpackage

`default_nettype wire

/* design/lcdtc_regfile.sv */
// Register window of the LCD timing controller: decode, read mux, writes.
// Keeps running sums of the timing fields for the line and frame compares.
// Depends on lcdtc_pkg.
`default_nettype none

module lcdtc_regfile (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lcdtc_pkg::item_t     req,
    input  wire logic                 fire,
    output logic [31:0]               rdata,
    output logic                      mapped,
    output lcdtc_pkg::timing_cfg_t    cfg
);
    import lcdtc_pkg::*;

    logic [31:0] control_reg;
    logic [31:0] sync_diff_reg;
    logic [31:0] mode_reg;
    logic [31:0] hbp_reg;
    logic [31:0] hsw_reg;
    logic [31:0] hfp_reg;
    logic [31:0] hres_reg;
    logic [31:0] vbp_reg;
    logic [31:0] vsw_reg;
    logic [31:0] vfp_reg;
    logic [31:0] vres_reg;
    logic [31:0] scale_reg [4];

    logic [31:0] period_reg;
    logic [31:0] vstart_reg;
    logic [31:0] vend_reg;
    logic [31:0] vtotal_reg;
    logic [31:0] period_next;
    logic [31:0] vstart_next;
    logic [31:0] vend_next;
    logic [31:0] vtotal_next;

    logic        is_h;
    logic        is_vstart;
    logic        is_vres;
    logic        is_vfp;
    logic        we;
    logic [31:0] delta;

    always_comb
    begin
        rdata     = '0;
        mapped    = 1'b1;
        is_h      = 1'b0;
        is_vstart = 1'b0;
        is_vres   = 1'b0;
        is_vfp    = 1'b0;
        case (req.byte_offset)
            OFS_CONTROL:   rdata = control_reg;
            OFS_SYNC_DIFF: rdata = sync_diff_reg;
            OFS_MODE:      rdata = mode_reg;
            OFS_HBP:
            begin
                rdata = hbp_reg;
                is_h  = 1'b1;
            end
            OFS_HSW:
            begin
                rdata = hsw_reg;
                is_h  = 1'b1;
            end
            OFS_HFP:
            begin
                rdata = hfp_reg;
                is_h  = 1'b1;
            end
            OFS_HRES:
            begin
                rdata = hres_reg;
                is_h  = 1'b1;
            end
            OFS_VBP:
            begin
                rdata     = vbp_reg;
                is_vstart = 1'b1;
            end
            OFS_VSW:
            begin
                rdata     = vsw_reg;
                is_vstart = 1'b1;
            end
            OFS_VFP:
            begin
                rdata  = vfp_reg;
                is_vfp = 1'b1;
            end
            OFS_VRES:
            begin
                rdata   = vres_reg;
                is_vres = 1'b1;
            end
            OFS_SCALE0, OFS_SCALE1, OFS_SCALE2, OFS_SCALE3:
                rdata = scale_reg[req.byte_offset[3:2]];
            default:       mapped = 1'b0;
        endcase
    end

    assign we    = fire && (req.operation == OP_WRITE) && mapped;
    assign delta = req.write_data - rdata;

    always_comb
    begin
        period_next = period_reg;
        vstart_next = vstart_reg;
        vend_next   = vend_reg;
        vtotal_next = vtotal_reg;
        if (we)
        begin
            if (is_h)
                period_next = period_reg + delta;
            if (is_vstart)
                vstart_next = vstart_reg + delta;
            if (is_vstart || is_vres)
                vend_next = vend_reg + delta;
            if (is_vstart || is_vres || is_vfp)
                vtotal_next = vtotal_reg + delta;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg   <= '0;
            sync_diff_reg <= '0;
            mode_reg      <= '0;
            hbp_reg       <= RST_HBP;
            hsw_reg       <= RST_HSW;
            hfp_reg       <= RST_HFP;
            hres_reg      <= RST_HRES;
            vbp_reg       <= RST_VBP;
            vsw_reg       <= RST_VSW;
            vfp_reg       <= RST_VFP;
            vres_reg      <= RST_VRES;
            for (int i = 0; i < 4; i++)
                scale_reg[i] <= '0;
            period_reg    <= RST_PERIOD;
            vstart_reg    <= RST_VSTART;
            vend_reg      <= RST_VEND;
            vtotal_reg    <= RST_VTOTAL;
        end
        else
        begin
            period_reg <= period_next;
            vstart_reg <= vstart_next;
            vend_reg   <= vend_next;
            vtotal_reg <= vtotal_next;
            if (we)
            begin
                case (req.byte_offset)
                    OFS_CONTROL:   control_reg   <= req.write_data;
                    OFS_SYNC_DIFF: sync_diff_reg <= req.write_data;
                    OFS_MODE:      mode_reg      <= req.write_data;
                    OFS_HBP:       hbp_reg       <= req.write_data;
                    OFS_HSW:       hsw_reg       <= req.write_data;
                    OFS_HFP:       hfp_reg       <= req.write_data;
                    OFS_HRES:      hres_reg      <= req.write_data;
                    OFS_VBP:       vbp_reg       <= req.write_data;
                    OFS_VSW:       vsw_reg       <= req.write_data;
                    OFS_VFP:       vfp_reg       <= req.write_data;
                    OFS_VRES:      vres_reg      <= req.write_data;
                    OFS_SCALE0, OFS_SCALE1, OFS_SCALE2, OFS_SCALE3:
                        scale_reg[req.byte_offset[3:2]] <= req.write_data;
                    default:       ;
                endcase
            end
        end
    end

    assign cfg.enable  = (control_reg[1:0] == 2'b11) && (hres_reg != '0);
    assign cfg.period  = period_reg;
    assign cfg.v_start = vstart_reg;
    assign cfg.v_end   = vend_reg;
    assign cfg.v_total = vtotal_reg;

endmodule

`default_nettype wire

/* design/lcdtc_timing.sv */
// Pixel and scanline counters of the LCD timing controller.
// Produces hsync, vsync and the line number from the register sums.
// Depends on lcdtc_pkg.
`default_nettype none

module lcdtc_timing (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire lcdtc_pkg::timing_cfg_t cfg,
    input  wire logic                   tick,
    input  wire logic                   clear,
    output lcdtc_pkg::timing_status_t   status
);
    import lcdtc_pkg::*;

    logic [31:0] pixel_reg;
    logic [31:0] pixel_next;
    logic [31:0] line_reg;
    logic [31:0] line_next;
    logic [31:0] pixel_inc;
    logic [31:0] line_inc;
    logic        line_hit;
    logic        hs;
    logic        vs;

    assign pixel_inc = pixel_reg + 32'd1;
    assign line_inc  = line_reg + 32'd1;
    assign line_hit  = (cfg.period == '0) ? (pixel_inc != '0) : (pixel_inc >= cfg.period);

    always_comb
    begin
        pixel_next = pixel_reg;
        line_next  = line_reg;
        hs         = 1'b0;
        vs         = 1'b0;
        if (clear)
        begin
            pixel_next = '0;
            line_next  = '0;
        end
        else if (tick && cfg.enable)
        begin
            if (line_hit)
            begin
                pixel_next = '0;
                hs         = 1'b1;
                line_next  = line_inc;
                if (line_inc < cfg.v_start)
                    line_next = line_inc;
                else if (line_inc < cfg.v_end)
                    line_next = line_inc;
                else if (line_inc == cfg.v_end)
                    vs = 1'b1;
                else if (line_inc >= cfg.v_total)
                    line_next = '0;
            end
            else
            begin
                pixel_next = pixel_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_reg <= '0;
            line_reg  <= '0;
        end
        else
        begin
            pixel_reg <= pixel_next;
            line_reg  <= line_next;
        end
    end

    assign status.hsync = hs;
    assign status.vsync = vs;
    assign status.line  = line_next;

endmodule

`default_nettype wire

/* design/lcd_timing_controller_core.sv */
// LCD timing controller top level: input register, register window, counters, result register.
// Each item is held in the input register, and its result then in the result register.
// Throughput: one item per cycle unless result_ready stalls; each item is fully handled
// in the cycle it leaves the input register, and the result register decouples the output side.
// Reset: rst_n empties both stages and resets window and counters, but not the payloads.
// Depends on lcdtc_pkg, lcdtc_regfile, lcdtc_timing.
`default_nettype none

module lcd_timing_controller_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire lcdtc_pkg::item_t   item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output lcdtc_pkg::result_t      result
);
    import lcdtc_pkg::*;

    item_t          item_reg;
    logic           item_valid_reg;
    result_t        result_reg;
    result_t        result_next;
    logic           result_valid_reg;

    logic           advance;
    logic           fire;
    logic [31:0]    rdata;
    logic           mapped;
    logic           clear;
    logic           tick;
    timing_cfg_t    cfg;
    timing_status_t status;

    assign advance    = !result_valid_reg || result_ready;
    assign fire       = item_valid_reg && advance;
    assign item_ready = !item_valid_reg || advance;

    lcdtc_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (item_reg),
        .fire   (fire),
        .rdata  (rdata),
        .mapped (mapped),
        .cfg    (cfg)
    );

    assign clear = fire && (item_reg.operation == OP_WRITE)
                   && (mapped || (item_reg.byte_offset == OFS_IGNORED));
    assign tick  = fire && (item_reg.operation == OP_TICK);

    lcdtc_timing u_timing (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .tick   (tick),
        .clear  (clear),
        .status (status)
    );

    always_comb
    begin
        result_next              = '0;
        result_next.line_number  = status.line;
        result_next.hsync_pulse  = status.hsync;
        result_next.vsync_pulse  = status.vsync;
        case (item_reg.operation)
            OP_READ:
            begin
                result_next.read_data    = mapped ? rdata : '0;
                result_next.access_error = !mapped;
            end
            OP_WRITE:
                result_next.access_error = !mapped && (item_reg.byte_offset != OFS_IGNORED);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
                item_valid_reg <= item_valid;
            if (advance)
                result_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
        if (fire)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

/* design/lcdtc_checker.sv */
// Port-level checks for the LCD timing controller, bound to the top level.
// Depends on lcdtc_pkg and lcd_timing_controller_core.
`default_nettype none

module lcdtc_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_ready,
    input wire lcdtc_pkg::item_t   item,
    input wire logic               result_valid,
    input wire logic               result_ready,
    input wire lcdtc_pkg::result_t result
);
    import lcdtc_pkg::*;

    // hold a stalled item
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("item changed while stalled");

    // hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_vsync_needs_hsync: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.vsync_pulse |-> result.hsync_pulse)
        else $error("vsync without hsync");

    a_error_no_sync: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.access_error |-> !result.hsync_pulse && result.read_data == '0)
        else $error("error result carries data or sync");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with empty output");

endmodule

bind lcd_timing_controller_core lcdtc_checker u_lcdtc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
